// ===== hdl/csna_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csna_pkg
// Types and constants of the serial-over-CAN node addressing block.
// ----------------------------------------------------------------------------
package csna_pkg;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned UUID_W    = 48;
    localparam int unsigned NODE_W    = 16;
    localparam int unsigned MAX_BYTES = 8;
    localparam int unsigned UUID_BYTES = 6;
    localparam int unsigned TDATA_W   = 80;
    localparam int unsigned CFG_IDX_W = 3;

    // kind of one request on the slave side
    typedef enum logic [1:0] {
        KIND_FRAME    = 2'd0,
        KIND_TX_CHUNK = 2'd1,
        KIND_START    = 2'd2
    } t_kind;

    // action of one result on the master side
    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_TRANSMIT  = 2'd1,
        ACT_DELIVER   = 2'd2,
        ACT_RESET_REQ = 2'd3
    } t_action;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_ID      = 3'd0,
        CFG_ASSIGN_ID     = 3'd1,
        CFG_UUID_REPLY_ID = 3'd2,
        CFG_SHORT_UUID    = 3'd3
    } t_cfg_idx;

    localparam logic [ID_W-1:0] QUERY_ID_RST      = 11'd801;
    localparam logic [ID_W-1:0] ASSIGN_ID_RST     = 11'd802;
    localparam logic [ID_W-1:0] UUID_REPLY_ID_RST = 11'd803;

endpackage
`default_nettype wire

// ===== hdl/can_serial_node_addressing.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_serial_node_addressing
// Node side of serial-over-CAN addressing: UUID query reply, node id
// assignment, ping, serial delivery, reset request and serial transmit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Carries
// s_axis    in         s_axis_tvalid/tready      rx frame, tx chunk or start
// m_axis    out        m_axis_tvalid/tready      one result per request
// cfg       in         i_cfg_valid/o_cfg_ready   register index and data
//
// Every request gives exactly one result (input register, then result
// register). One request per cycle is taken while m_axis is not stalled.
// The node id is updated as a request moves into the result register, so
// the next request already sees it. Reset (synchronous, active low) clears
// the node id and loads the register defaults. A stalled master side holds
// the result; the input register still takes one more request meanwhile.
// ----------------------------------------------------------------------------
module can_serial_node_addressing (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave side
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [10:0] rx_id, [14:11] byte_count, [46:15] bytes_low,
    // [78:47] bytes_high, [79] zero
    input  wire logic [csna_pkg::TDATA_W-1:0]      s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]                        s_axis_tuser,
    // master side
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [10:0] frame_id, [14:11] frame_len, [46:15] payload_low,
    // [78:47] payload_high, [79] zero
    output logic [csna_pkg::TDATA_W-1:0]           m_axis_tdata,
    // [1:0] action
    output logic [1:0]                             m_axis_tuser,
    // configuration write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [csna_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [csna_pkg::UUID_W-1:0]       i_cfg_data
);

    localparam int unsigned ID_W   = csna_pkg::ID_W;
    localparam int unsigned LEN_W  = csna_pkg::LEN_W;
    localparam int unsigned WORD_W = csna_pkg::WORD_W;
    localparam int unsigned NODE_W = csna_pkg::NODE_W;

    // configuration
    logic [ID_W-1:0]              r_query_id;
    logic [ID_W-1:0]              r_assign_id;
    logic [ID_W-1:0]              r_uuid_reply_id;
    logic [csna_pkg::UUID_W-1:0]  r_short_uuid;

    // state
    logic [NODE_W-1:0]            r_node_id;
    logic [NODE_W-1:0]            n_node_id;

    // input register
    logic                         r_in_vld;
    logic [1:0]                   r_in_kind;
    logic [ID_W-1:0]              r_in_rx_id;
    logic [LEN_W-1:0]             r_in_count;
    logic [WORD_W-1:0]            r_in_lo;
    logic [WORD_W-1:0]            r_in_hi;

    // result register
    logic                         r_out_vld;
    csna_pkg::t_action            r_out_action;
    logic [ID_W-1:0]              r_out_frame_id;
    logic [LEN_W-1:0]             r_out_len;
    logic [WORD_W-1:0]            r_out_lo;
    logic [WORD_W-1:0]            r_out_hi;

    csna_pkg::t_action            n_action;
    logic [ID_W-1:0]              n_frame_id;
    logic [LEN_W-1:0]             n_len;
    logic [2*WORD_W-1:0]          n_raw;
    logic [2*WORD_W-1:0]          n_payload;

    logic                         adv;
    logic                         s_acc;
    logic [LEN_W-1:0]             count;
    logic [ID_W-1:0]              reply_id;
    logic                         assigned;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id      <= csna_pkg::QUERY_ID_RST;
            r_assign_id     <= csna_pkg::ASSIGN_ID_RST;
            r_uuid_reply_id <= csna_pkg::UUID_REPLY_ID_RST;
            r_short_uuid    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csna_pkg::CFG_QUERY_ID:      r_query_id      <= i_cfg_data[ID_W-1:0];
                csna_pkg::CFG_ASSIGN_ID:     r_assign_id     <= i_cfg_data[ID_W-1:0];
                csna_pkg::CFG_UUID_REPLY_ID: r_uuid_reply_id <= i_cfg_data[ID_W-1:0];
                csna_pkg::CFG_SHORT_UUID:    r_short_uuid    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_kind  <= s_axis_tuser;
            r_in_rx_id <= s_axis_tdata[10:0];
            r_in_count <= s_axis_tdata[14:11];
            r_in_lo    <= s_axis_tdata[46:15];
            r_in_hi    <= s_axis_tdata[78:47];
        end
    end

    // ---------------- decision logic ----------------
    always_comb begin
        count      = r_in_count[LEN_W-1] ? LEN_W'(csna_pkg::MAX_BYTES) : r_in_count;
        reply_id   = r_node_id[ID_W-1:0] + ID_W'(1);
        assigned   = (r_node_id != '0);
        n_action   = csna_pkg::ACT_NONE;
        n_frame_id = '0;
        n_len      = '0;
        n_raw      = '0;
        n_node_id  = r_node_id;

        unique case (r_in_kind)
            csna_pkg::KIND_START: begin
                n_action   = csna_pkg::ACT_TRANSMIT;
                n_frame_id = r_uuid_reply_id;
                n_len      = LEN_W'(csna_pkg::UUID_BYTES);
                n_raw      = {16'd0, r_short_uuid};
            end
            csna_pkg::KIND_TX_CHUNK: begin
                if (assigned && count != '0) begin
                    n_action   = csna_pkg::ACT_TRANSMIT;
                    n_frame_id = reply_id;
                    n_len      = count;
                    n_raw      = {r_in_hi, r_in_lo};
                end
            end
            csna_pkg::KIND_FRAME: begin
                if (!assigned) begin
                    priority if (r_in_rx_id == r_query_id && count == '0) begin
                        n_action   = csna_pkg::ACT_TRANSMIT;
                        n_frame_id = r_uuid_reply_id;
                        n_len      = LEN_W'(csna_pkg::UUID_BYTES);
                        n_raw      = {16'd0, r_short_uuid};
                    end else if (r_in_rx_id == r_assign_id) begin
                        // bytes 2..7 carry the UUID, bytes 0..1 the new id
                        if ({r_in_hi, r_in_lo[31:16]} == r_short_uuid) begin
                            n_node_id = r_in_lo[15:0];
                        end
                    end else begin
                    end
                end else begin
                    priority if ({5'd0, r_in_rx_id} == r_node_id) begin
                        if (count == '0) begin
                            n_action   = csna_pkg::ACT_TRANSMIT;
                            n_frame_id = reply_id;
                        end else begin
                            n_action = csna_pkg::ACT_DELIVER;
                            n_len    = count;
                            n_raw    = {r_in_hi, r_in_lo};
                        end
                    end else if (r_in_rx_id == r_query_id && count != '0) begin
                        if (r_in_lo[15:0] == r_node_id) begin
                            n_node_id = '0;
                            n_action  = csna_pkg::ACT_RESET_REQ;
                        end
                    end else begin
                    end
                end
            end
            default: ;
        endcase

        // drop bytes beyond the length
        for (int b = 0; b < csna_pkg::MAX_BYTES; b++) begin
            n_payload[8*b +: 8] = (LEN_W'(b) < n_len) ? n_raw[8*b +: 8] : 8'd0;
        end
    end

    // ---------------- node id and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_node_id <= n_node_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_out_action   <= n_action;
            r_out_frame_id <= n_frame_id;
            r_out_len      <= n_len;
            r_out_lo       <= n_payload[WORD_W-1:0];
            r_out_hi       <= n_payload[2*WORD_W-1:WORD_W];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {1'b0, r_out_hi, r_out_lo, r_out_len, r_out_frame_id};

    // ---------------- assertions ----------------
    a_reset_clears_id : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_vld && n_action == csna_pkg::ACT_RESET_REQ) |=> (r_node_id == '0))
        else $error("reset request did not clear node id");

    a_none_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == csna_pkg::ACT_NONE) |-> (m_axis_tdata == '0))
        else $error("empty result carries data");

    a_deliver_no_id : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == csna_pkg::ACT_DELIVER) |-> (r_out_frame_id == '0))
        else $error("delivery carries a frame id");

    a_ready_only_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_vld && !m_axis_tready && r_in_vld))
        else $error("slave side blocked without a stall");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN serial node addressing block. A directed
// table covers the corner cases right after reset; randomized phases follow,
// each with its own register setting and one of four idle patterns. Every
// request is scored against typed rows or an in-bench model of the node state.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_DIRECTED = 26;
    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 230;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] rx_id;
        logic [3:0]  count;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_node_request;

    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] frame_id;
        logic [3:0]  len;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_node_result;

    typedef struct packed {
        t_node_request req;
        logic          typed;
        t_node_result  expected;
    } t_directed_row;

    localparam t_node_result NO_RESULT =
        '{csna_pkg::ACT_NONE, 11'd0, 4'd0, 32'd0, 32'd0};
    localparam t_node_result UUID_AT_RESET =
        '{csna_pkg::ACT_TRANSMIT, csna_pkg::UUID_REPLY_ID_RST, 4'd6, 32'd0, 32'd0};
    localparam t_node_result RESET_REQUEST =
        '{csna_pkg::ACT_RESET_REQ, 11'd0, 4'd0, 32'd0, 32'd0};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [csna_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [csna_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [csna_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [csna_pkg::UUID_W-1:0]    i_cfg_data = '0;

    // node model state and registers
    logic [10:0] query_id_q;
    logic [10:0] assign_id_q;
    logic [10:0] uuid_reply_id_q;
    logic [47:0] dev_uuid_q;
    logic [15:0] node_id_q;

    t_node_result pending_results [$];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int action_counts [4] = '{0, 0, 0, 0};

    // expectations that can be read off the protocol are typed in
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{'{csna_pkg::KIND_START, 11'd0, 4'd0, 32'd0, 32'd0}, 1'b1, UUID_AT_RESET},
        '{'{KIND_UNUSED, 11'd2047, 4'd15, ONES, ONES}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_TX_CHUNK, 11'd0, 4'd8, ONES, ONES}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd0, 32'd0, 32'd0}, 1'b1, UUID_AT_RESET},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd5, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0,
          NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd8, 32'd0, 32'd0}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd8, 32'h0001_0005, 32'd0}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd8, 32'h0000_07FF, 32'd0}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd8, 32'h0000_0010, 32'd0}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd2047, 4'd0, 32'd0, 32'd0}, 1'b1,
          '{csna_pkg::ACT_TRANSMIT, 11'd0, 4'd0, 32'd0, 32'd0}},
        '{'{csna_pkg::KIND_FRAME, 11'd2047, 4'd15, ONES, ONES}, 1'b1,
          '{csna_pkg::ACT_DELIVER, 11'd0, 4'd8, ONES, ONES}},
        '{'{csna_pkg::KIND_FRAME, 11'd2047, 4'd3, ONES, ONES}, 1'b1,
          '{csna_pkg::ACT_DELIVER, 11'd0, 4'd3, 32'h00FF_FFFF, 32'd0}},
        '{'{csna_pkg::KIND_TX_CHUNK, 11'd0, 4'd0, ONES, ONES}, 1'b1, NO_RESULT},
        '{'{csna_pkg::KIND_TX_CHUNK, 11'd0, 4'd5, 32'hA5A5_A5A5, ONES}, 1'b1,
          '{csna_pkg::ACT_TRANSMIT, 11'd0, 4'd5, 32'hA5A5_A5A5, 32'h0000_00FF}},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd2, 32'h0000_07FE, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd2, 32'hFFFF_07FF, ONES}, 1'b1, RESET_REQUEST},
        '{'{csna_pkg::KIND_FRAME, 11'd0, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd2, 32'h0000_FFFF, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd2047, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_TX_CHUNK, 11'd0, 4'd1, 32'h0000_005A, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd8, 32'h1234_FFFF, 32'd0}, 1'b1,
          RESET_REQUEST},
        '{'{csna_pkg::KIND_FRAME, 11'd802, 4'd6, 32'h0000_0321, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd0, 32'd0, 32'd0}, 1'b0, NO_RESULT},
        '{'{csna_pkg::KIND_FRAME, 11'd801, 4'd4, 32'hDEAD_BEEF, 32'h0BAD_F00D}, 1'b0,
          NO_RESULT},
        '{'{csna_pkg::KIND_START, 11'd1234, 4'd9, ONES, ONES}, 1'b1, UUID_AT_RESET}
    };

    can_serial_node_addressing u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(64'd5_000_000);
        $display("status: fail");
        $finish;
    end

    // zero the payload bytes beyond len
    function automatic t_node_result build_result(input csna_pkg::t_action act,
                                                  input logic [10:0] id,
                                                  input logic [3:0] len,
                                                  input logic [31:0] lo,
                                                  input logic [31:0] hi);
        t_node_result r;
        logic [63:0] bytes;
        bytes = {hi, lo};
        for (int i = 0; i < 8; i++) begin
            if (i >= len) begin
                bytes[8*i +: 8] = 8'h00;
            end
        end
        r.action = act;
        r.frame_id = id;
        r.len = len;
        r.lo = bytes[31:0];
        r.hi = bytes[63:32];
        return r;
    endfunction

    function automatic t_node_result next_node_result(input t_node_request rq);
        logic [3:0]  cnt;
        logic [10:0] reply_id;
        t_node_result r;
        cnt = (rq.count > 4'd8) ? 4'd8 : rq.count;
        reply_id = node_id_q[10:0] + 11'd1;
        r = NO_RESULT;
        if (rq.kind == csna_pkg::KIND_START) begin
            r = build_result(csna_pkg::ACT_TRANSMIT, uuid_reply_id_q,
                             4'(csna_pkg::UUID_BYTES),
                             dev_uuid_q[31:0], {16'd0, dev_uuid_q[47:32]});
        end else if (rq.kind == csna_pkg::KIND_TX_CHUNK) begin
            if (node_id_q != 16'd0 && cnt != 4'd0) begin
                r = build_result(csna_pkg::ACT_TRANSMIT, reply_id, cnt, rq.lo, rq.hi);
            end
        end else if (rq.kind == csna_pkg::KIND_FRAME) begin
            if (node_id_q == 16'd0) begin
                if (rq.rx_id == query_id_q && cnt == 4'd0) begin
                    r = build_result(csna_pkg::ACT_TRANSMIT, uuid_reply_id_q,
                                     4'(csna_pkg::UUID_BYTES),
                                     dev_uuid_q[31:0], {16'd0, dev_uuid_q[47:32]});
                end else if (rq.rx_id == assign_id_q) begin
                    if ({rq.hi, rq.lo[31:16]} == dev_uuid_q) begin
                        node_id_q = rq.lo[15:0];
                    end
                end
            end else if ({5'd0, rq.rx_id} == node_id_q) begin
                if (cnt == 4'd0) begin
                    r = build_result(csna_pkg::ACT_TRANSMIT, reply_id, 4'd0, 32'd0, 32'd0);
                end else begin
                    r = build_result(csna_pkg::ACT_DELIVER, 11'd0, cnt, rq.lo, rq.hi);
                end
            end else if (rq.rx_id == query_id_q && cnt != 4'd0
                         && rq.lo[15:0] == node_id_q) begin
                node_id_q = 16'd0;
                r = RESET_REQUEST;
            end
        end
        return r;
    endfunction

    // mostly well-formed protocol traffic, steered by the current node state
    function automatic t_node_request pick_request();
        t_node_request rq;
        logic [15:0] new_id;
        logic [47:0] carried;
        int roll;
        int sub;
        rq.kind = csna_pkg::KIND_FRAME;
        rq.rx_id = 11'($urandom_range(2047));
        rq.count = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        rq.lo = $urandom;
        rq.hi = $urandom;
        roll = $urandom_range(99);
        sub = $urandom_range(99);
        case ($urandom_range(15))
            0: new_id = 16'd0;
            1: new_id = 16'($urandom_range(65535));
            default: new_id = 16'($urandom_range(1, 2047));
        endcase
        if (roll < 5) begin
            rq.kind = csna_pkg::KIND_START;
        end else if (roll < 8) begin
            rq.kind = KIND_UNUSED;
        end else if (roll < 23) begin
            rq.kind = csna_pkg::KIND_TX_CHUNK;
        end else if (node_id_q == 16'd0) begin
            if (sub < 25) begin
                rq.rx_id = query_id_q;
                if (sub < 20) begin
                    rq.count = 4'd0;
                end
            end else if (sub < 70) begin
                rq.rx_id = assign_id_q;
                carried = dev_uuid_q;
                if (sub >= 62) begin
                    carried = carried ^ (48'd1 << $urandom_range(47));
                end
                {rq.hi, rq.lo[31:16]} = carried;
                rq.lo[15:0] = new_id;
            end
        end else begin
            if (sub < 45) begin
                rq.rx_id = node_id_q[10:0];
            end else if (sub < 60) begin
                rq.rx_id = query_id_q;
                rq.lo[15:0] = node_id_q;
                if (rq.count == 4'd0 && sub < 57) begin
                    rq.count = 4'd1;
                end
            end else if (sub < 70) begin
                rq.rx_id = query_id_q;
            end else if (sub < 75) begin
                rq.rx_id = assign_id_q;
            end
        end
        return rq;
    endfunction

    task automatic send_request(input t_node_request rq, output t_node_result predicted);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.kind;
        s_axis_tdata <= {1'b0, rq.hi, rq.lo, rq.count, rq.rx_id};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = next_node_result(rq);
        requests_sent++;
    endtask

    task automatic cfg_write(input csna_pkg::t_cfg_idx idx,
                             input logic [csna_pkg::UUID_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            csna_pkg::CFG_QUERY_ID:      query_id_q = value[10:0];
            csna_pkg::CFG_ASSIGN_ID:     assign_id_q = value[10:0];
            csna_pkg::CFG_UUID_REPLY_ID: uuid_reply_id_q = value[10:0];
            csna_pkg::CFG_SHORT_UUID:    dev_uuid_q = value;
            default: ;
        endcase
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_node_result exp_r;
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            results_seen++;
            action_counts[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual action %0h",
                         $time, m_axis_tuser);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("action", 32'(exp_r.action), 32'(m_axis_tuser));
                check_field("frame_id", 32'(exp_r.frame_id), 32'(m_axis_tdata[10:0]));
                check_field("frame_len", 32'(exp_r.len), 32'(m_axis_tdata[14:11]));
                check_field("payload_low", exp_r.lo, m_axis_tdata[46:15]);
                check_field("payload_high", exp_r.hi, m_axis_tdata[78:47]);
            end
        end
    end

    initial begin
        t_node_result predicted;
        logic [csna_pkg::UUID_W-1:0] cfg_vals [4];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        query_id_q = csna_pkg::QUERY_ID_RST;
        assign_id_q = csna_pkg::ASSIGN_ID_RST;
        uuid_reply_id_q = csna_pkg::UUID_REPLY_ID_RST;
        dev_uuid_q = '0;
        node_id_q = '0;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_request(directed_rows[i].req, predicted);
            if (directed_rows[i].typed) begin
                pending_results.push_back(directed_rows[i].expected);
            end else begin
                pending_results.push_back(predicted);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            // first two phases take the extremes; upper data bits are junk on ids
            case (p)
                0: cfg_vals = '{48'd0, 48'd0, 48'd0, 48'd0};
                1: cfg_vals = '{48'h7FF, 48'h7FF, 48'h7FF, 48'hFFFF_FFFF_FFFF};
                default: begin
                    for (int r = 0; r < 3; r++) begin
                        cfg_vals[r] = {16'($urandom_range(65535)), 32'($urandom)};
                    end
                    cfg_vals[3] = {16'($urandom_range(65535)), 32'($urandom)};
                end
            endcase
            cfg_write(csna_pkg::CFG_QUERY_ID, cfg_vals[0]);
            cfg_write(csna_pkg::CFG_ASSIGN_ID, cfg_vals[1]);
            cfg_write(csna_pkg::CFG_UUID_REPLY_ID, cfg_vals[2]);
            cfg_write(csna_pkg::CFG_SHORT_UUID, cfg_vals[3]);
            i_cfg_valid <= 1'b0;
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
                    drain_results();
                end
                send_request(pick_request(), predicted);
                pending_results.push_back(predicted);
            end
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        $display("covered %0d requests in %0d register settings, %0d results scored",
                 requests_sent, NUM_PHASES + 1, results_seen);
        $display("results by action: none %0d, transmit %0d, deliver %0d, reset %0d",
                 action_counts[csna_pkg::ACT_NONE], action_counts[csna_pkg::ACT_TRANSMIT],
                 action_counts[csna_pkg::ACT_DELIVER], action_counts[csna_pkg::ACT_RESET_REQ]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/csna_pkg.sv
hdl/can_serial_node_addressing.sv
verif/tb_top.sv
